// ===== rtl/pdi_pkg.sv =====
`default_nettype none

package pdi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // dt = (ms * 65536 + 500) / 1000 = ((ms * 8192 + 62) * ceil(2^36 / 125)) >> 36,
    // exact for every 16-bit ms
    localparam logic [28:0] DT_BIAS  = 29'd62;
    localparam logic [29:0] DT_RECIP = 30'd549755814;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_RECORD  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic KIND_ADD = 1'b0;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        particle_mass;
        logic signed [31:0] drag_factor;
        logic [30:0]        drag_threshold;
        logic [30:0]        lifetime_ms;
        logic [31:0]        rgba;
        logic [15:0]        elapsed_ms;
    } pdi_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         slot;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [31:0]        out_rgba;
        logic [6:0]         live_count;
        logic               last;
    } pdi_out_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        mass;
        logic signed [31:0] kf;
        logic [30:0]        thr;
        logic signed [31:0] life;
        logic [31:0]        color;
    } pdi_part_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        rgba;
    } pdi_rec_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ADD, OP_TICK, OP_DT, OP_RD_I, OP_LOAD, OP_DROP, OP_RD_LAST,
        OP_COPY, OP_SQ0, OP_SQ1, OP_SQRT, OP_COEF, OP_COEF2, OP_FX, OP_FY,
        OP_PX, OP_PY, OP_DFX, OP_DIVX, OP_VX, OP_DIVY, OP_VY, OP_WB,
        OP_EMPTY, OP_EMIT_RD, OP_EMIT
    } pdi_op_t;

    typedef struct packed {
        logic walk_done;
        logic is_last;
        logic dead;
        logic n_zero;
        logic emit_last;
        logic out_free;
        logic div_busy;
        logic sqrt_busy;
    } pdi_sts_t;

    // floor(p / 65536), saturated to signed 32 bit
    function automatic logic signed [31:0] sat_asr16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p >>> 16;
        if (t[65:31] == '0 || t[65:31] == '1) begin
            return t[31:0];
        end
        return t[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic signed [31:0] sat66(input logic signed [65:0] t);
        if (t[65:31] == '0 || t[65:31] == '1) begin
            return t[31:0];
        end
        return t[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/particle_drag_integrator.sv =====
// Add item: one result, loaded the cycle after acceptance; a new item is taken once it leaves.
// Tick item: dt first (reciprocal multiply, registered), then per surviving particle one
// 32-step square root and two 64-step divisions on shared bit-serial units, per removed
// particle a drop or a copy of the last one, then records drain; one item is in work at a time.
// Reset (aresetn low, synchronous) empties the particle table and the result register.
`default_nettype none

module particle_drag_integrator
    import pdi_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire pdi_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output pdi_out_t     m_data
);

    pdi_op_t  op;
    pdi_sts_t sts;

    pdi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .op      (op)
    );

    pdi_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .s_data  (s_data),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/pdi_div.sv =====
`default_nettype none

module pdi_div
    import pdi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);

    logic [6:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [63:0] q_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, q_reg[63]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 7'd64;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            q_reg   <= dividend;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/pdi_sqrt.sv =====
`default_nettype none

module pdi_sqrt
    import pdi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic [31:0]      root
);

    logic [5:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] trial_rem;
    logic [35:0] trial;
    logic        fits;

    assign trial_rem = {rem_reg, rad_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = trial_rem >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // two radicand bits per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= fits ? 34'(trial_rem - trial) : trial_rem[33:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/pdi_dp.sv =====
`default_nettype none

module pdi_dp
    import pdi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire pdi_op_t  op,
    input  wire pdi_in_t  s_data,
    output pdi_sts_t      sts,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pdi_out_t      m_data
);

    pdi_part_t mem [TABLE_DEPTH];
    pdi_rec_t  rbuf [TABLE_DEPTH];

    pdi_part_t rdata_reg;
    pdi_rec_t  rb_rdata_reg;
    pdi_part_t rec_reg;
    pdi_part_t wdata;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;

    logic [CNT_W-1:0] total_reg, i_reg, n_reg, k_reg;
    logic [15:0] ms_reg;
    logic [22:0] dt_reg;
    logic [28:0] dt_scaled;
    logic signed [32:0] life_reg;
    logic signed [31:0] coef_reg, fx_reg, fy_reg;
    logic quad_reg, neg_reg;
    logic [63:0] acc_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic mul_en;

    logic div_start, sqrt_start;
    logic [63:0] div_dividend, div_q;
    logic [31:0] div_divisor, sqrt_root;
    logic div_busy, sqrt_busy;
    logic signed [65:0] prod_abs;
    logic signed [65:0] dv;

    pdi_out_t m_data_reg;
    logic     m_valid_reg;
    logic     out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign prod_abs  = prod_reg[65] ? -prod_reg : prod_reg;
    assign dv        = neg_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign dt_scaled = {s_data.elapsed_ms, 13'b0} + DT_BIAS;

    // particle memory ports
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_reg[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = i_reg[ADDR_W-1:0];
        wdata   = rec_reg;
        case (op)
            OP_RD_I: begin
                rd_en = 1'b1;
            end
            OP_RD_LAST: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(total_reg - CNT_W'(1));
            end
            OP_ADD: begin
                wr_en   = total_reg < CNT_W'(TABLE_DEPTH);
                wr_addr = total_reg[ADDR_W-1:0];
                wdata   = '{px: s_data.pos_x, py: s_data.pos_y, vx: s_data.vel_x,
                            vy: s_data.vel_y, mass: s_data.particle_mass,
                            kf: s_data.drag_factor, thr: s_data.drag_threshold,
                            life: {1'b0, s_data.lifetime_ms}, color: s_data.rgba};
            end
            OP_COPY: begin
                wr_en = 1'b1;
                wdata = rdata_reg;
            end
            OP_WB: begin
                wr_en = 1'b1;
                wdata = rec_reg;
                wdata.life = life_reg[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (op == OP_WB) begin
            rbuf[n_reg[ADDR_W-1:0]] <= '{x: rec_reg.px, y: rec_reg.py, rgba: rec_reg.color};
        end
        if (op == OP_EMIT_RD) begin
            rb_rdata_reg <= rbuf[k_reg[ADDR_W-1:0]];
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_en = 1'b1;
        mul_a  = 33'(rec_reg.vx);
        mul_b  = 33'(rec_reg.vx);
        case (op)
            OP_TICK: begin
                mul_a = $signed({4'b0, dt_scaled});
                mul_b = $signed({3'b0, DT_RECIP});
            end
            OP_SQ0: begin
            end
            OP_SQ1: begin
                mul_a = 33'(rec_reg.vy);
                mul_b = 33'(rec_reg.vy);
            end
            OP_COEF: begin
                mul_a = 33'(rec_reg.kf);
                mul_b = $signed({1'b0, sqrt_root});
            end
            OP_FX: begin
                mul_a = 33'(coef_reg);
                mul_b = 33'(rec_reg.vx);
            end
            OP_FY: begin
                mul_a = 33'(coef_reg);
                mul_b = 33'(rec_reg.vy);
            end
            OP_PX: begin
                mul_a = $signed({10'b0, dt_reg});
                mul_b = 33'(rec_reg.vx);
            end
            OP_PY: begin
                mul_a = $signed({10'b0, dt_reg});
                mul_b = 33'(rec_reg.vy);
            end
            OP_DFX: begin
                mul_a = $signed({10'b0, dt_reg});
                mul_b = 33'(fx_reg);
            end
            OP_VX: begin
                mul_a = $signed({10'b0, dt_reg});
                mul_b = 33'(fy_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_abs[63:0];
        div_divisor  = {1'b0, rec_reg.mass};
        sqrt_start   = op == OP_SQRT;
        case (op)
            OP_DIVX, OP_DIVY: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    pdi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    pdi_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg + prod_reg[63:0]),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // per-tick and per-particle working registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_TICK: begin
                ms_reg <= s_data.elapsed_ms;
            end
            OP_DT: begin
                dt_reg <= prod_reg[58:36];
            end
            OP_LOAD: begin
                rec_reg  <= rdata_reg;
                life_reg <= 33'(rdata_reg.life) - $signed({17'b0, ms_reg});
            end
            OP_SQ1: begin
                acc_reg <= prod_reg[63:0];
            end
            OP_COEF: begin
                quad_reg <= sqrt_root > {1'b0, rec_reg.thr};
                coef_reg <= rec_reg.kf;
            end
            OP_COEF2: begin
                if (quad_reg) begin
                    coef_reg <= sat_asr16(prod_reg);
                end
            end
            OP_FY: begin
                fx_reg <= sat_asr16(prod_reg);
            end
            OP_PX: begin
                fy_reg <= sat_asr16(prod_reg);
            end
            OP_PY: begin
                rec_reg.px <= sat66(66'(rec_reg.px) + (prod_reg >>> 16));
            end
            OP_DFX: begin
                rec_reg.py <= sat66(66'(rec_reg.py) + (prod_reg >>> 16));
            end
            OP_DIVX, OP_DIVY: begin
                neg_reg <= prod_reg[65];
            end
            OP_VX: begin
                if (rec_reg.mass != '0) begin
                    rec_reg.vx <= sat66(66'(rec_reg.vx) - dv);
                end
            end
            OP_VY: begin
                if (rec_reg.mass != '0) begin
                    rec_reg.vy <= sat66(66'(rec_reg.vy) - dv);
                end
            end
            default: begin
            end
        endcase
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            i_reg     <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
        end else begin
            case (op)
                OP_ADD: begin
                    if (total_reg < CNT_W'(TABLE_DEPTH)) begin
                        total_reg <= total_reg + CNT_W'(1);
                    end
                end
                OP_TICK: begin
                    i_reg <= '0;
                    n_reg <= '0;
                    k_reg <= '0;
                end
                OP_DROP, OP_COPY: begin
                    total_reg <= total_reg - CNT_W'(1);
                end
                OP_WB: begin
                    i_reg <= i_reg + CNT_W'(1);
                    n_reg <= n_reg + CNT_W'(1);
                end
                OP_EMIT: begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (op == OP_ADD || op == OP_EMPTY || op == OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_ADD: begin
                if (total_reg < CNT_W'(TABLE_DEPTH)) begin
                    m_data_reg <= '{status: ST_ADDED, slot: total_reg[ADDR_W-1:0],
                                    out_x: s_data.pos_x, out_y: s_data.pos_y,
                                    out_rgba: s_data.rgba,
                                    live_count: total_reg + CNT_W'(1), last: 1'b1};
                end else begin
                    m_data_reg <= '{status: ST_DROPPED, slot: '0, out_x: '0, out_y: '0,
                                    out_rgba: '0, live_count: total_reg, last: 1'b1};
                end
            end
            OP_EMPTY: begin
                m_data_reg <= '{status: ST_EMPTY, slot: '0, out_x: '0, out_y: '0,
                                out_rgba: '0, live_count: total_reg, last: 1'b1};
            end
            OP_EMIT: begin
                m_data_reg <= '{status: ST_RECORD, slot: k_reg[ADDR_W-1:0],
                                out_x: rb_rdata_reg.x, out_y: rb_rdata_reg.y,
                                out_rgba: rb_rdata_reg.rgba, live_count: total_reg,
                                last: k_reg == n_reg - CNT_W'(1)};
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.walk_done = i_reg >= total_reg;
    assign sts.is_last   = i_reg == total_reg - CNT_W'(1);
    assign sts.dead      = life_reg[32] || life_reg == '0;
    assign sts.n_zero    = n_reg == '0;
    assign sts.emit_last = k_reg == n_reg - CNT_W'(1);
    assign sts.out_free  = out_free;
    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;

endmodule

`default_nettype wire

// ===== rtl/pdi_ctrl.sv =====
`default_nettype none

module pdi_ctrl
    import pdi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_kind,
    output logic          s_ready,
    input  wire pdi_sts_t sts,
    output pdi_op_t       op
);

    typedef enum logic [22:0] {
        S_IDLE      = 23'd1 << 0,
        S_DT_WAIT   = 23'd1 << 1,
        S_CHECK     = 23'd1 << 2,
        S_LOAD      = 23'd1 << 3,
        S_EVAL      = 23'd1 << 4,
        S_COPY      = 23'd1 << 5,
        S_SQ1       = 23'd1 << 6,
        S_SQRT      = 23'd1 << 7,
        S_SQRT_WAIT = 23'd1 << 8,
        S_COEF2     = 23'd1 << 9,
        S_FX        = 23'd1 << 10,
        S_FY        = 23'd1 << 11,
        S_PX        = 23'd1 << 12,
        S_PY        = 23'd1 << 13,
        S_DFX       = 23'd1 << 14,
        S_DIVX      = 23'd1 << 15,
        S_DIVX_WAIT = 23'd1 << 16,
        S_DIVY      = 23'd1 << 17,
        S_DIVY_WAIT = 23'd1 << 18,
        S_WB        = 23'd1 << 19,
        S_FINISH    = 23'd1 << 20,
        S_EMIT_RD   = 23'd1 << 21,
        S_EMIT      = 23'd1 << 22
    } pdi_state_t;

    pdi_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE && sts.out_free;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && sts.out_free) begin
                    if (s_kind == KIND_ADD) begin
                        op = OP_ADD;
                    end else begin
                        op         = OP_TICK;
                        state_next = S_DT_WAIT;
                    end
                end
            end
            S_DT_WAIT: begin
                if (!sts.div_busy) begin
                    op         = OP_DT;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.walk_done) begin
                    state_next = S_FINISH;
                end else begin
                    op         = OP_RD_I;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                op         = OP_LOAD;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (sts.dead) begin
                    // pull the last particle into this slot and look at it again, or drop it if it is the last
                    if (sts.is_last) begin
                        op         = OP_DROP;
                        state_next = S_CHECK;
                    end else begin
                        op         = OP_RD_LAST;
                        state_next = S_COPY;
                    end
                end else begin
                    op         = OP_SQ0;
                    state_next = S_SQ1;
                end
            end
            S_COPY: begin
                op         = OP_COPY;
                state_next = S_CHECK;
            end
            S_SQ1: begin
                op         = OP_SQ1;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                op         = OP_SQRT;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!sts.sqrt_busy) begin
                    op         = OP_COEF;
                    state_next = S_COEF2;
                end
            end
            S_COEF2: begin
                op         = OP_COEF2;
                state_next = S_FX;
            end
            S_FX: begin
                op         = OP_FX;
                state_next = S_FY;
            end
            S_FY: begin
                op         = OP_FY;
                state_next = S_PX;
            end
            S_PX: begin
                op         = OP_PX;
                state_next = S_PY;
            end
            S_PY: begin
                op         = OP_PY;
                state_next = S_DFX;
            end
            S_DFX: begin
                op         = OP_DFX;
                state_next = S_DIVX;
            end
            S_DIVX: begin
                op         = OP_DIVX;
                state_next = S_DIVX_WAIT;
            end
            S_DIVX_WAIT: begin
                if (!sts.div_busy) begin
                    op         = OP_VX;
                    state_next = S_DIVY;
                end
            end
            S_DIVY: begin
                op         = OP_DIVY;
                state_next = S_DIVY_WAIT;
            end
            S_DIVY_WAIT: begin
                if (!sts.div_busy) begin
                    op         = OP_VY;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                op         = OP_WB;
                state_next = S_CHECK;
            end
            S_FINISH: begin
                if (sts.n_zero) begin
                    if (sts.out_free) begin
                        op         = OP_EMPTY;
                        state_next = S_IDLE;
                    end
                end else begin
                    op         = OP_EMIT_RD;
                    state_next = S_EMIT;
                end
            end
            S_EMIT_RD: begin
                op         = OP_EMIT_RD;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    op         = OP_EMIT;
                    state_next = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench
    import pdi_pkg::*;
;

    localparam int N_RANDOM    = 270;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pdi_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pdi_out_t m_data;

    particle_drag_integrator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // particle table mirror
    logic signed [31:0] tbl_px [TABLE_DEPTH];
    logic signed [31:0] tbl_py [TABLE_DEPTH];
    logic signed [31:0] tbl_vx [TABLE_DEPTH];
    logic signed [31:0] tbl_vy [TABLE_DEPTH];
    logic [30:0]        tbl_mass [TABLE_DEPTH];
    logic signed [31:0] tbl_kf [TABLE_DEPTH];
    logic [30:0]        tbl_thr [TABLE_DEPTH];
    logic signed [31:0] tbl_life [TABLE_DEPTH];
    logic [31:0]        tbl_color [TABLE_DEPTH];
    int                 live_total = 0;

    pdi_in_t  pending_items[$];
    pdi_out_t expected_results[$];
    int       errors = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       records_seen = 0;
    int       drops_seen = 0;
    int       cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_sender = 1'b0;

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fff_ffff;
        if (v < -96'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [95:0] p;
        p = 96'(a) * 96'(b);
        return clamp32(p >>> 16);
    endfunction

    function automatic void euler_step(input int i, input logic signed [31:0] dt);
        logic signed [31:0] v [2];
        logic signed [31:0] f [2];
        logic signed [31:0] coef;
        logic [63:0]        sq;
        logic [31:0]        speed;
        logic signed [95:0] p;
        logic signed [95:0] q;
        logic signed [95:0] np;
        v[0] = tbl_vx[i];
        v[1] = tbl_vy[i];
        sq = 64'(96'(v[0]) * 96'(v[0])) + 64'(96'(v[1]) * 96'(v[1]));
        speed = root64(sq);
        if ({1'b0, speed} > {2'b0, tbl_thr[i]}) begin
            p = 96'(tbl_kf[i]) * 96'($signed({1'b0, speed}));
            coef = clamp32(p >>> 16);
            for (int j = 0; j < 2; j++) f[j] = qmul(coef, v[j]);
        end else begin
            for (int j = 0; j < 2; j++) f[j] = qmul(tbl_kf[i], v[j]);
        end
        for (int j = 0; j < 2; j++) begin
            np = 96'(j == 0 ? tbl_px[i] : tbl_py[i]) + ((96'(dt) * 96'(v[j])) >>> 16);
            if (j == 0) tbl_px[i] = clamp32(np); else tbl_py[i] = clamp32(np);
            if (tbl_mass[i] != 0) begin
                p = 96'(dt) * 96'(f[j]);
                // truncate toward zero
                q = (p < 0 ? -p : p) / 96'($signed({65'b0, tbl_mass[i]}));
                if (p < 0) q = -q;
                if (j == 0) tbl_vx[i] = clamp32(96'(v[j]) - q);
                else tbl_vy[i] = clamp32(96'(v[j]) - q);
            end
        end
    endfunction

    task automatic predict_item(input pdi_in_t it);
        pdi_out_t r;
        pdi_out_t recs[$];
        logic [31:0] dt_u;
        logic signed [31:0] dt;
        logic signed [63:0] lf;
        int i;
        int l;
        r = '0;
        if (it.kind == KIND_ADD) begin
            if (live_total >= TABLE_DEPTH) begin
                r.status = ST_DROPPED;
                r.live_count = 7'(live_total);
                r.last = 1'b1;
            end else begin
                l = live_total;
                tbl_px[l] = it.pos_x;
                tbl_py[l] = it.pos_y;
                tbl_vx[l] = it.vel_x;
                tbl_vy[l] = it.vel_y;
                tbl_mass[l] = it.particle_mass;
                tbl_kf[l] = it.drag_factor;
                tbl_thr[l] = it.drag_threshold;
                tbl_life[l] = $signed({1'b0, it.lifetime_ms});
                tbl_color[l] = it.rgba;
                live_total++;
                r.status = ST_ADDED;
                r.slot = 6'(l);
                r.out_x = it.pos_x;
                r.out_y = it.pos_y;
                r.out_rgba = it.rgba;
                r.live_count = 7'(live_total);
                r.last = 1'b1;
            end
            expected_results.push_back(r);
            return;
        end
        dt_u = (32'(it.elapsed_ms) * 32'd65536 + 32'd500) / 32'd1000;
        dt = $signed(dt_u);
        i = 0;
        while (i < live_total) begin
            lf = 64'(tbl_life[i]) - 64'(it.elapsed_ms);
            if (lf <= 0) begin
                // pull the last particle in and re-examine this slot
                l = live_total - 1;
                tbl_px[i] = tbl_px[l]; tbl_py[i] = tbl_py[l];
                tbl_vx[i] = tbl_vx[l]; tbl_vy[i] = tbl_vy[l];
                tbl_mass[i] = tbl_mass[l]; tbl_kf[i] = tbl_kf[l];
                tbl_thr[i] = tbl_thr[l]; tbl_life[i] = tbl_life[l];
                tbl_color[i] = tbl_color[l];
                live_total = l;
            end else begin
                tbl_life[i] = lf[31:0];
                euler_step(i, dt);
                r = '0;
                r.status = ST_RECORD;
                r.slot = 6'(i);
                r.out_x = tbl_px[i];
                r.out_y = tbl_py[i];
                r.out_rgba = tbl_color[i];
                recs.push_back(r);
                i++;
            end
        end
        if (recs.size() == 0) begin
            r = '0;
            r.status = ST_EMPTY;
            r.live_count = 7'(live_total);
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        foreach (recs[k]) begin
            recs[k].live_count = 7'(live_total);
            recs[k].last = (k == recs.size() - 1);
            expected_results.push_back(recs[k]);
        end
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic pdi_in_t make_add(input bit tame);
        pdi_in_t it;
        it = '0;
        it.kind = KIND_ADD;
        if (tame) begin
            it.pos_x = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            it.pos_y = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            it.vel_x = $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
            it.vel_y = $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
            it.particle_mass = 31'($urandom_range(32'h0000_4000, 32'h0010_0000));
            it.drag_factor = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0000_8000;
            it.drag_threshold = 31'($urandom_range(0, 32'h0020_0000));
            it.lifetime_ms = 31'($urandom_range(1, 3000));
        end else begin
            it.pos_x = rand_edge32();
            it.pos_y = rand_edge32();
            it.vel_x = rand_edge32();
            it.vel_y = rand_edge32();
            it.particle_mass = 31'($urandom_range(1, 32'h7fff_ffff));
            it.drag_factor = rand_edge32();
            it.drag_threshold = 31'($urandom);
            it.lifetime_ms = 31'($urandom);
        end
        it.rgba = $urandom;
        it.elapsed_ms = 16'($urandom);
        return it;
    endfunction

    function automatic pdi_in_t make_tick(input int ms);
        pdi_in_t it;
        it = '0;
        it.kind = ~KIND_ADD;
        it.elapsed_ms = 16'(ms);
        it.pos_x = $urandom;
        it.rgba = $urandom;
        return it;
    endfunction

    logic s_ready_q = 1'b0;
    logic m_valid_q = 1'b0;
    int   stall = 0;

    // driver
    int gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                if (gap == 0 && !hold_sender && pending_items.size() != 0) begin
                    s_data <= pending_items.pop_front();
                    items_sent++;
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (gap > 0) gap--;
                else if (!hold_sender && pending_items.size() != 0) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    items_sent++;
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
                end
            end
        end
    end

    // capture acceptance at the rising edge; predict there
    always @(posedge aclk) begin
        cycles++;
        s_ready_q <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_item(s_data);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d", m_data.status);
                    errors++;
                end else begin
                    pdi_out_t e;
                    e = expected_results.pop_front();
                    if (m_data.status == ST_RECORD) records_seen++;
                    if (m_data.status == ST_DROPPED) drops_seen++;
                    if (e.status !== m_data.status) begin
                        $error("status exp %0d got %0d", e.status, m_data.status); errors++;
                    end
                    if (e.slot !== m_data.slot) begin
                        $error("slot exp %0d got %0d", e.slot, m_data.slot); errors++;
                    end
                    if (e.out_x !== m_data.out_x) begin
                        $error("out_x exp %h got %h", e.out_x, m_data.out_x); errors++;
                    end
                    if (e.out_y !== m_data.out_y) begin
                        $error("out_y exp %h got %h", e.out_y, m_data.out_y); errors++;
                    end
                    if (e.out_rgba !== m_data.out_rgba) begin
                        $error("out_rgba exp %h got %h", e.out_rgba, m_data.out_rgba);
                        errors++;
                    end
                    if (e.live_count !== m_data.live_count) begin
                        $error("live_count exp %0d got %0d", e.live_count,
                               m_data.live_count);
                        errors++;
                    end
                    if (e.last !== m_data.last) begin
                        $error("last exp %0d got %0d", e.last, m_data.last); errors++;
                    end
                end
            end
        end
    end

    // receiver stalls, drawn per result
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_ready && m_valid_q) begin
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end
    always @(posedge aclk) m_valid_q <= m_valid && m_ready;

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        pdi_in_t it;
        int waited;
        // directed: empty tick, extremes, zero life
        pending_items.push_back(make_tick(0));
        it = make_add(1'b1);
        it.lifetime_ms = 0;
        pending_items.push_back(it);
        it = make_add(1'b1);
        it.pos_x = 32'sh7fff_ffff; it.vel_x = 32'sh7fff_ffff;
        it.pos_y = 32'sh8000_0000; it.vel_y = 32'sh8000_0000;
        it.drag_factor = 32'sh7fff_ffff; it.drag_threshold = '0;
        it.particle_mass = 31'd1; it.lifetime_ms = 31'h7fff_ffff;
        it.rgba = 32'hffff_ffff;
        pending_items.push_back(it);
        it = make_add(1'b1);
        it.drag_factor = 32'sh8000_0000; it.drag_threshold = 31'h7fff_ffff;
        it.particle_mass = 31'h7fff_ffff; it.lifetime_ms = 31'd5;
        it.rgba = '0;
        pending_items.push_back(it);
        pending_items.push_back(make_tick(65535));
        pending_items.push_back(make_tick(0));
        pending_items.push_back(make_tick(1));
        pending_items.push_back(make_tick(500));
        repeat (6) pending_items.push_back(make_add(1'b1));
        pending_items.push_back(make_tick(3));
        pending_items.push_back(make_tick(65535));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0);
        // let the block drain completely before sending more
        hold_sender = 1'b1;
        waited = 0;
        while ((s_valid || expected_results.size() != 0) && waited < 200_000) begin
            @(posedge aclk);
            waited++;
        end
        hold_sender = 1'b0;

        // fill the table to the brim, then overflow it
        repeat (66) begin
            it = make_add(1'b1);
            it.lifetime_ms = 31'($urandom_range(20, 40));
            pending_items.push_back(it);
        end
        pending_items.push_back(make_tick(10));
        pending_items.push_back(make_tick(60));

        for (int n = 0; n < N_RANDOM - 68; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pending_items.push_back(make_add(1'b1));
                4:          pending_items.push_back(make_add(1'b0));
                5, 6, 7:    pending_items.push_back(make_tick($urandom_range(1, 200)));
                8:          pending_items.push_back(make_tick($urandom_range(0, 2000)));
                default:    pending_items.push_back(make_tick($urandom));
            endcase
        end

        wait (pending_items.size() == 0 && !s_valid);
        waited = 0;
        while (expected_results.size() != 0 && waited < 2_000_000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (300) @(posedge aclk);

        $display("Sent %0d items (adds, ticks, table overflow, expiring particles),",
                 items_sent);
        $display("checked %0d results: %0d particle records, %0d drops.",
                 results_seen, records_seen, drops_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
